@@ hdl/sprc_pkg.sv @@
// Shared types and constants for the stepper pulse ramp chunker.
package sprc_pkg;

	// Widths of the shared divider: dividend up to 49 bits, divisor 32 bits.
	localparam int DIV_DW = 49;
	localparam int DIV_VW = 32;

	// Widths of the serial multiplier: step times chunk length.
	localparam int MUL_AW = 25;
	localparam int MUL_BW = 32;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Chunk error shift (rate moves at most 1/32) and Newton iteration count.
	localparam int ERR_SHIFT    = 5;
	localparam int NEWTON_STEPS = 3;

	// Configuration register indexes.
	localparam logic [2:0] REG_TOTAL_PULSES = 3'd0;
	localparam logic [2:0] REG_PULLIN_RATE  = 3'd1;
	localparam logic [2:0] REG_ACCEL_RATE   = 3'd2;
	localparam logic [2:0] REG_TIMER_HZ     = 3'd3;
	localparam logic [2:0] REG_MIN_PERIOD   = 3'd4;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_DW-1:0] quo;
		logic [DIV_VW-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [MUL_PW-1:0] prod;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_BRAKE_WAIT,
		ST_ROOM,
		ST_BYERR_WAIT,
		ST_TOGO_GO,
		ST_TOGO_WAIT,
		ST_COUNT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_MOVE_HALF,
		ST_MOVE_FULL,
		ST_NEWT_GO,
		ST_NEWT_WAIT,
		ST_PER_GO,
		ST_PER_WAIT,
		ST_FINISH
	} state_t;

endpackage

@@ hdl/sprc_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by every division.
module sprc_div import sprc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_DW + 1);

	logic [DIV_VW-1:0] rem_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] div_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_VW:0]   trial;
	logic [DIV_VW:0]   diff;
	logic              ge;

	// Trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[DIV_DW-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	// Control: count iterations, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift in dividend bits, shift out quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
			quo_q <= {quo_q[DIV_DW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

@@ hdl/sprc_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
module sprc_mul import sprc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int CW = $clog2(MUL_BW + 1);

	logic [MUL_PW-1:0] acc_q;
	logic [MUL_PW-1:0] mcand_q;
	logic [MUL_BW-1:0] mplier_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	// Control: count multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(MUL_BW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: add the shifted multiplicand for each set bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= {{MUL_BW{1'b0}}, req.a};
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[MUL_PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MUL_BW-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

@@ hdl/stepper_pulse_ramp_chunker.sv @@
// Top level: sequencer and state of the stepper pulse ramp chunker.
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tdata: pulse_index, chunk_budget, target_rate;
//                                   tuser: stop_request
//  m_*       out  tvalid/tready     tdata: pulse_count, timer_period, period_frac,
//                                   rate_out; tlast: train_last
//  cfg_*     in   cfg_we            cfg_index, cfg_data
//
// A request runs from accept to the result beat through seven passes of
// the shared restoring divider (brake distance, error bound, steps to goal,
// three Newton steps, timer period), one pass of the serial multiplier and
// the steps that set the count and move the ramp.
// A configuration write reloads the ramp state in the following cycle.
// A finished result waits in the output register; the next request is
// taken meanwhile but cannot retire until that register is free.
module stepper_pulse_ramp_chunker import sprc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // pulse_index[31:0], chunk_budget[63:32], target_rate[87:64]
	input  logic         s_tuser,   // stop_request
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // pulse_count, timer_period, period_frac, rate_out
	output logic         m_tlast,   // train_last
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// Configuration registers
	logic [31:0] total_q;
	logic [23:0] pullin_q;
	logic [23:0] accel_q;
	logic [31:0] timer_q;
	logic [31:0] minp_q;
	logic        reload_q;

	// Ramp state
	logic [31:0] rate_now_q;
	logic [47:0] rs_q;
	logic [47:0] ps_q;

	// Per-request working registers
	state_t      state_q, state_d;
	logic [31:0] idx_q;
	logic [31:0] budget_q;
	logic [23:0] target_q;
	logic        stop_q;
	logic [24:0] step_q;
	logic        bounded_q;
	logic [31:0] remain_q;
	logic [47:0] tsq_q;
	logic [47:0] brake_q;
	logic [47:0] goal_q;
	logic [31:0] room_q;
	logic [48:0] byerr_q;
	logic [48:0] togo_q;
	logic [31:0] count_q;
	logic [56:0] span_q;
	logic [47:0] half_q;
	logic [47:0] newrs_q;
	logic [31:0] x_q;
	logic [1:0]  iter_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] o_count_q;
	logic [31:0] o_period_q;
	logic [23:0] o_frac_q;
	logic [23:0] o_rate_q;
	logic        o_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic [23:0] sq_a;
	logic [47:0] sq_p;
	logic        accept;
	logic        out_free;

	// Move v toward goal by at most d
	function automatic logic [47:0] move_to(input logic [47:0] v, input logic [47:0] goal,
			input logic [56:0] d);
		logic [57:0] sum;
		logic [47:0] over;
		begin
			sum  = {10'b0, v} + {1'b0, d};
			over = v - goal;
			if (v < goal) begin
				move_to = (sum > {10'b0, goal}) ? goal : sum[47:0];
			end else if (v > goal) begin
				move_to = ({9'b0, over} > d) ? (v - d[47:0]) : goal;
			end else begin
				move_to = v;
			end
		end
	endfunction

	sprc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	sprc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));

	// Squarer shared by reload and target square
	assign sq_a = reload_q ? pullin_q : target_q;
	assign sq_p = {24'b0, sq_a} * {24'b0, sq_a};

	assign s_tready = (state_q == ST_IDLE) && !reload_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit requests
	always_comb begin
		logic [47:0] diff;
		diff             = (goal_q > rs_q) ? (goal_q - rs_q) : (rs_q - goal_q);
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		mul_req.start    = 1'b0;
		mul_req.a        = step_q;
		mul_req.b        = count_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_PREP;
			end
			ST_PREP: begin
				div_req.start    = 1'b1;
				div_req.dividend = (rs_q > ps_q) ? {1'b0, rs_q - ps_q} : '0;
				div_req.divisor  = {7'b0, accel_q, 1'b0};
				state_d          = ST_BRAKE_WAIT;
			end
			ST_BRAKE_WAIT: begin
				if (div_rsp.done) state_d = ST_ROOM;
			end
			ST_ROOM: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, rs_q};
				div_req.divisor  = {3'b0, step_q, 4'b0};
				state_d          = ST_BYERR_WAIT;
			end
			ST_BYERR_WAIT: begin
				if (div_rsp.done) state_d = ST_TOGO_GO;
			end
			ST_TOGO_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, diff} + {24'b0, step_q} - 49'd1;
				div_req.divisor  = {7'b0, step_q};
				state_d          = ST_TOGO_WAIT;
			end
			ST_TOGO_WAIT: begin
				if (div_rsp.done) state_d = ST_COUNT;
			end
			ST_COUNT: state_d = ST_MUL_GO;
			ST_MUL_GO: begin
				mul_req.start = 1'b1;
				state_d       = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (mul_rsp.done) state_d = ST_MOVE_HALF;
			end
			ST_MOVE_HALF: state_d = ST_MOVE_FULL;
			ST_MOVE_FULL: state_d = ST_NEWT_GO;
			ST_NEWT_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, half_q};
				div_req.divisor  = x_q;
				state_d          = ST_NEWT_WAIT;
			end
			ST_NEWT_WAIT: begin
				if (div_rsp.done) begin
					state_d = (iter_q == 2'(NEWTON_STEPS - 1)) ? ST_PER_GO : ST_NEWT_GO;
				end
			end
			ST_PER_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {17'b0, timer_q};
				div_req.divisor  = x_q;
				state_d          = ST_PER_WAIT;
			end
			ST_PER_WAIT: begin
				if (div_rsp.done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration writes and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= 32'd0;
			pullin_q   <= 24'd1;
			accel_q    <= 24'd1000;
			timer_q    <= 32'd1000000;
			minp_q     <= 32'd1;
			reload_q   <= 1'b0;
			rate_now_q <= 32'd1;
			rs_q       <= 48'd1;
			ps_q       <= 48'd1;
		end else begin
			reload_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TOTAL_PULSES: begin total_q <= cfg_data; reload_q <= 1'b1; end
					REG_PULLIN_RATE:  begin pullin_q <= cfg_data[23:0]; reload_q <= 1'b1; end
					REG_ACCEL_RATE:   begin accel_q <= cfg_data[23:0]; reload_q <= 1'b1; end
					REG_TIMER_HZ:     begin timer_q <= cfg_data; reload_q <= 1'b1; end
					REG_MIN_PERIOD:   begin minp_q <= cfg_data; reload_q <= 1'b1; end
					default: ;
				endcase
			end
			if (reload_q) begin
				ps_q       <= sq_p;
				rs_q       <= sq_p;
				rate_now_q <= {8'b0, pullin_q};
			end else if (state_q == ST_PER_WAIT && div_rsp.done) begin
				rate_now_q <= x_q;
				rs_q       <= newrs_q;
			end
		end
	end

	// Per-request datapath
	always_ff @(posedge clk) begin
		logic [31:0] room;
		logic [31:0] gap;
		logic [48:0] c;
		logic [49:0] nsum;
		logic [31:0] nx;
		logic        brk;
		if (accept) begin
			idx_q    <= s_tdata[31:0];
			budget_q <= s_tdata[63:32];
			target_q <= (s_tdata[87:64] < pullin_q) ? pullin_q : s_tdata[87:64];
			stop_q   <= s_tuser;
		end
		unique case (state_q)
			ST_PREP: begin
				step_q    <= {accel_q, 1'b0};
				bounded_q <= (total_q != 32'd0);
				if (total_q != 32'd0) begin
					remain_q <= (idx_q > total_q) ? 32'd0 : (total_q - idx_q);
				end else begin
					remain_q <= budget_q;
				end
				tsq_q <= sq_p;
			end
			ST_BRAKE_WAIT: begin
				if (div_rsp.done) begin
					brake_q <= (step_q != 25'd0 && rs_q > ps_q) ? div_rsp.quo[47:0] : 48'd0;
				end
			end
			ST_ROOM: begin
				brk    = stop_q || (bounded_q && {16'b0, remain_q} <= brake_q);
				goal_q <= brk ? ps_q : tsq_q;
				room = (remain_q < budget_q) ? remain_q : budget_q;
				if (!brk && bounded_q) begin
					gap = remain_q - brake_q[31:0];
					if (rs_q < tsq_q) gap = {1'b0, gap[31:1]};
					if (gap < room) room = gap;
				end
				room_q <= room;
			end
			ST_BYERR_WAIT: begin
				if (div_rsp.done) byerr_q <= div_rsp.quo;
			end
			ST_TOGO_WAIT: begin
				if (div_rsp.done) togo_q <= div_rsp.quo;
			end
			ST_COUNT: begin
				c = {17'b0, room_q};
				if (step_q != 25'd0 && rs_q != goal_q) begin
					c = (byerr_q < togo_q) ? byerr_q : togo_q;
				end
				if (c > {17'b0, room_q}) c = {17'b0, room_q};
				if (c == 49'd0) c = 49'd1;
				if (stop_q && rs_q <= ps_q) c = 49'd1;
				count_q <= c[31:0];
			end
			ST_MUL_WAIT: begin
				if (mul_rsp.done) span_q <= mul_rsp.prod;
			end
			ST_MOVE_HALF: begin
				half_q <= move_to(rs_q, goal_q, {1'b0, span_q[56:1]});
				x_q    <= (rate_now_q != 32'd0) ? rate_now_q : 32'd1;
				iter_q <= 2'd0;
			end
			ST_MOVE_FULL: begin
				newrs_q <= move_to(rs_q, goal_q, span_q);
			end
			ST_NEWT_WAIT: begin
				if (div_rsp.done) begin
					nsum   = {18'b0, x_q} + {1'b0, div_rsp.quo};
					nx     = nsum[32:1];
					x_q    <= (nx != 32'd0) ? nx : 32'd1;
					iter_q <= iter_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// Result payload, captured when the period division ends
	always_ff @(posedge clk) begin
		if (state_q == ST_PER_WAIT && div_rsp.done) begin
			o_count_q <= count_q;
			o_rate_q  <= x_q[23:0];
			o_last_q  <= stop_q && (newrs_q <= ps_q);
			if (div_rsp.quo[31:0] < minp_q) begin
				o_period_q <= minp_q;
				o_frac_q   <= 24'd0;
			end else begin
				o_period_q <= div_rsp.quo[31:0];
				o_frac_q   <= div_rsp.rem[23:0];
			end
		end
	end

	// Output beat valid: set on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Staged result moves to the port register only when it is free
	logic [111:0] m_data_q;
	logic         m_last_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_data_q <= {o_rate_q, o_frac_q, o_period_q, o_count_q};
			m_last_q <= o_last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("request taken while one is in work");
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEWT_GO || state_q == ST_PER_GO) |-> (x_q != 32'd0))
		else $error("zero divisor in rate path");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:0] != 32'd0)) else $error("empty chunk");
`endif

endmodule

@@ bench/tb_top.sv @@
// Testbench for the stepper pulse ramp chunker: directed table, directed register cases, then random chunk requests.
module tb_top import sprc_pkg::*; ();

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [87:0]  s_tdata;   // pulse_index, chunk_budget, target_rate
	logic         s_tuser;   // stop_request
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;   // pulse_count, timer_period, period_frac, rate_out
	logic         m_tlast;   // train_last
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	stepper_pulse_ramp_chunker uut (.*);

	typedef struct {
		logic [31:0] count;
		logic [31:0] period;
		logic [23:0] frac;
		logic [23:0] rate;
		logic        last;
	} chunk_t;

	typedef struct {
		logic [31:0] idx;
		logic [31:0] budget;
		logic [23:0] target;
		logic        stop;
		logic        typed;   // expected chunk given in the row
		chunk_t      exp;
	} row_t;

	// Ramp configuration and state mirrored by the predictor
	logic [31:0] total_q, pullin_q, accel_q, hz_q, minper_q;
	logic [31:0] rate_q;
	logic [63:0] rsq_q, psq_q;

	chunk_t exp_chunks[$];
	int     errors, cycles, n_items, n_last, n_cfg, n_floor;
	bit     idle_off;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Cycle counter with a hard limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] step_to(logic [63:0] v, logic [63:0] g, logic [63:0] d);
		if (v < g) return (v + d > g) ? g : v + d;
		if (v > g) return (v > g + d) ? v - d : g;
		return v;
	endfunction

	function automatic logic [31:0] sqrt_newton(logic [63:0] s, logic [31:0] seed);
		logic [31:0] x;
		logic [63:0] t;
		x = (seed != 0) ? seed : 32'd1;
		for (int i = 0; i < NEWTON_STEPS; i++) begin
			t = ({32'd0, x} + s / {32'd0, x}) / 2;
			x = t[31:0];
			if (x == 0) x = 1;
		end
		return x;
	endfunction

	// Reload ramp state to pull-in
	task automatic reload_ramp();
		psq_q = {32'd0, pullin_q} * {32'd0, pullin_q};
		rate_q = pullin_q;
		rsq_q = psq_q;
	endtask

	// Compute the next chunk and advance the ramp state
	function automatic chunk_t next_chunk(logic [31:0] idx, logic [31:0] bud,
			logic [23:0] tgt_in, logic stop);
		logic [31:0] tgt, per, fr;
		logic [63:0] stp, rem, brk, goal, room, cnt, span, gap, by_err, diff, to_goal;
		logic bounded, braking;
		chunk_t c;
		tgt = (tgt_in < pullin_q) ? pullin_q : {8'd0, tgt_in};
		stp = 2 * {32'd0, accel_q};
		bounded = total_q != 0;
		if (bounded) rem = (idx > total_q) ? 0 : {32'd0, total_q - idx};
		else rem = {32'd0, bud};
		brk = (stp != 0 && rsq_q > psq_q) ? (rsq_q - psq_q) / stp : 0;
		braking = stop || (bounded && rem <= brk);
		goal = braking ? psq_q : {32'd0, tgt} * {32'd0, tgt};
		room = (rem < bud) ? rem : {32'd0, bud};
		if (!braking && bounded) begin
			gap = rem - brk;
			if (rsq_q < goal) gap = gap / 2;
			if (gap < room) room = gap;
		end
		cnt = room;
		if (stp != 0 && rsq_q != goal) begin
			by_err = rsq_q / (stp << (ERR_SHIFT - 1));
			diff = (goal > rsq_q) ? goal - rsq_q : rsq_q - goal;
			to_goal = (diff + stp - 1) / stp;
			cnt = (by_err < to_goal) ? by_err : to_goal;
		end
		if (cnt > room) cnt = room;
		if (cnt == 0) cnt = 1;
		if (stop && rsq_q <= psq_q) cnt = 1;
		span = stp * cnt;
		rate_q = sqrt_newton(step_to(rsq_q, goal, span / 2), rate_q);
		rsq_q = step_to(rsq_q, goal, span);
		per = hz_q / rate_q;
		fr = hz_q - per * rate_q;
		if (per < minper_q) begin
			per = minper_q;
			fr = 0;
			n_floor++;
		end
		c.count = cnt[31:0];
		c.period = per;
		c.frac = fr[23:0];
		c.rate = rate_q[23:0];
		c.last = stop && rsq_q <= psq_q;
		return c;
	endfunction

	task automatic wait_drained();
		while (exp_chunks.size() != 0) @(posedge clk);
		repeat (450) @(posedge clk);
		@(negedge clk);
	endtask

	// Write one register while idle; a write to a known register reloads the state
	task automatic write_reg(logic [2:0] ix, logic [31:0] val);
		wait_drained();
		cfg_we <= 1;
		cfg_index <= ix;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		unique case (ix)
			REG_TOTAL_PULSES: total_q = val;
			REG_PULLIN_RATE:  pullin_q = {8'd0, val[23:0]};
			REG_ACCEL_RATE:   accel_q = {8'd0, val[23:0]};
			REG_TIMER_HZ:     hz_q = val;
			REG_MIN_PERIOD:   minper_q = val;
			default: ;
		endcase
		if (ix <= REG_MIN_PERIOD) reload_ramp();
		n_cfg++;
	endtask

	// Present one request beat and queue its expected chunk
	task automatic send_req(logic [31:0] idx, logic [31:0] bud, logic [23:0] tgt,
			logic stop, logic typed, chunk_t typed_exp);
		chunk_t c;
		@(negedge clk);
		while (!idle_off && $urandom_range(99) < 35) @(negedge clk);
		s_tvalid <= 1;
		s_tdata <= {tgt, bud, idx};
		s_tuser <= stop;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		c = next_chunk(idx, bud, tgt, stop);
		if (typed) c = typed_exp;
		exp_chunks.push_back(c);
		n_items++;
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	// Receiver stalls
	always @(negedge clk)
		m_tready <= idle_off ? 1'b1 : ($urandom_range(99) >= 35);

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		chunk_t e;
		if (m_tvalid && m_tready) begin
			if (exp_chunks.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = exp_chunks.pop_front();
				if (m_tdata[31:0] !== e.count) begin
					$error("pulse_count exp %0d got %0d", e.count, m_tdata[31:0]); errors++;
				end
				if (m_tdata[63:32] !== e.period) begin
					$error("timer_period exp %0d got %0d", e.period, m_tdata[63:32]); errors++;
				end
				if (m_tdata[87:64] !== e.frac) begin
					$error("period_frac exp %0d got %0d", e.frac, m_tdata[87:64]); errors++;
				end
				if (m_tdata[111:88] !== e.rate) begin
					$error("rate_out exp %0d got %0d", e.rate, m_tdata[111:88]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("train_last exp %0d got %0d", e.last, m_tlast); errors++;
				end
				if (e.last) n_last++;
			end
		end
	end

	row_t dir_rows[$];
	chunk_t none;

	function automatic row_t mk(logic [31:0] i, logic [31:0] b, logic [23:0] t, logic s);
		row_t r;
		r.idx = i; r.budget = b; r.target = t; r.stop = s; r.typed = 0;
		r.exp = '{default: 0};
		return r;
	endfunction

	initial begin
		row_t r;
		logic [31:0] idx, tot;
		logic [23:0] tgt;
		errors = 0; cycles = 0; n_items = 0; n_last = 0; n_cfg = 0; n_floor = 0;
		idle_off = 0;
		none = '{default: 0};
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		total_q = 0; pullin_q = 1; accel_q = 1000; hz_q = 1000000; minper_q = 1;
		reload_ramp();
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed rows: after reset a stop at pull-in gives one pulse at rate 1
		r = mk(0, 100, 0, 1); r.typed = 1;
		r.exp = '{count: 1, period: 1000000, frac: 0, rate: 1, last: 1};
		dir_rows.push_back(r);
		dir_rows.push_back(mk(0, 0, 0, 0));              // zero room
		dir_rows.push_back(mk(0, 32'hFFFFFFFF, 24'hFFFFFF, 0));
		dir_rows.push_back(mk(5, 1000, 24'hFFFFFF, 0));
		dir_rows.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 500, 0));
		dir_rows.push_back(mk(10, 1000, 0, 1));
		dir_rows.push_back(mk(0, 1, 24'hFFFFFF, 1));
		foreach (dir_rows[k])
			send_req(dir_rows[k].idx, dir_rows[k].budget, dir_rows[k].target,
				dir_rows[k].stop, dir_rows[k].typed, dir_rows[k].exp);

		// Bounded move, index past total, floored period, extreme registers
		write_reg(REG_TOTAL_PULSES, 1000);
		write_reg(REG_PULLIN_RATE, 100);
		write_reg(REG_ACCEL_RATE, 50000);
		write_reg(REG_TIMER_HZ, 0);
		write_reg(REG_MIN_PERIOD, 7);
		send_req(2000, 10, 5000, 0, 0, none);
		send_req(0, 32'hFFFFFFFF, 5000, 0, 0, none);
		write_reg(REG_TIMER_HZ, 32'hFFFFFFFF);
		write_reg(REG_MIN_PERIOD, 0);
		write_reg(REG_PULLIN_RATE, 24'hFFFFFF);
		send_req(0, 100, 0, 0, 0, none);
		send_req(3, 100, 0, 1, 0, none);
		write_reg(REG_PULLIN_RATE, 0);
		write_reg(REG_ACCEL_RATE, 0);
		send_req(0, 100, 0, 0, 0, none);
		send_req(0, 100, 24'hFFFFFF, 0, 0, none);
		write_reg(REG_ACCEL_RATE, 24'hFFFFFF);
		write_reg(REG_TOTAL_PULSES, 32'hFFFFFFFF);
		send_req(0, 32'hFFFFFFFF, 24'hFFFFFF, 0, 0, none);
		send_req(32'hFFFFFFFE, 5, 24'hFFFFFF, 0, 0, none);
		write_reg(3'd7, 32'h12345678);   // index beyond the register file, ignored

		// Random moves: reconfigure, then a well-formed ramp with a stop, plus noise
		for (int ph = 0; ph < 24; ph++) begin
			idle_off = (ph == 10 || ph == 11);
			tot = ($urandom_range(3) == 0) ? 0 : $urandom_range(3000, 50);
			write_reg(REG_TOTAL_PULSES, tot);
			write_reg(REG_PULLIN_RATE, $urandom_range(9) == 0 ? $urandom : $urandom_range(2000));
			write_reg(REG_ACCEL_RATE, $urandom_range(9) == 0 ? $urandom : $urandom_range(200000));
			write_reg(REG_TIMER_HZ, $urandom_range(4) == 0 ? $urandom : 1000000);
			write_reg(REG_MIN_PERIOD, $urandom_range(3) == 0 ? $urandom_range(500) : 1);
			idx = 0;
			tgt = 24'($urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
			for (int k = 0; k < 35; k++) begin
				logic [31:0] bud;
				logic stp;
				chunk_t pk;
				bud = $urandom_range(7) == 0 ? $urandom : $urandom_range(400);
				stp = (k > 25) || ($urandom_range(19) == 0);
				if ($urandom_range(9) == 0) begin
					send_req($urandom, $urandom, 24'($urandom), 1'($urandom), 0, none);
				end else begin
					send_req(idx, bud, tgt, stp, 0, none);
					pk = exp_chunks[exp_chunks.size() - 1];
					idx = idx + pk.count;
				end
			end
		end
		idle_off = 0;

		wait_drained();
		$display("covered %0d requests, %0d register writes, %0d train ends, %0d floored",
			n_items, n_cfg, n_last, n_floor);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
